// ----- rtl/qrpt_pkg.sv -----
// Shared types, widths and helpers for the quaternion rigid point transform.
`default_nettype none
package qrpt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int QUAT_WIDTH  = 16;
    localparam int FRAC_SHIFT  = 14;
    localparam int QPROD_W     = 2 * QUAT_WIDTH;
    localparam int QSUM_W      = QPROD_W + 2;
    localparam int QRND_W      = QSUM_W - FRAC_SHIFT;
    localparam int PROD_W      = COORD_WIDTH + QUAT_WIDTH;
    localparam int ACC_W       = PROD_W + 2;
    localparam int RND_W       = ACC_W - FRAC_SHIFT;
    localparam int SUM_W       = RND_W + 1;
    localparam int INDEX_W     = 3;

    localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE   = 16'sd16384;
    localparam logic signed [QSUM_W-1:0]     Q28_ONE    = 34'sd268435456;
    localparam logic signed [QSUM_W-1:0]     QSUM_HALF  = 34'sd8192;
    localparam logic signed [ACC_W-1:0]      ACC_HALF   = ACC_W'(8192);
    localparam logic signed [QRND_W-1:0]     ENTRY_MAX  = 20'sd32767;
    localparam logic signed [QRND_W-1:0]     ENTRY_MIN  = -20'sd32768;
    localparam logic signed [SUM_W-1:0]      SUM_HI     =
        {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]      SUM_LO     =
        {{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [INDEX_W-1:0] {
        REG_QUAT_W  = 3'd0,
        REG_QUAT_X  = 3'd1,
        REG_QUAT_Y  = 3'd2,
        REG_QUAT_Z  = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } t_reg_index;

    typedef logic signed [QUAT_WIDTH-1:0]  t_entry;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [RND_W-1:0]       t_rnd;
    typedef t_entry [8:0]                  t_mat;
    typedef t_coord [2:0]                  t_vec;
    typedef t_rnd   [2:0]                  t_rvec;

    typedef struct packed {
        t_entry w;
        t_entry x;
        t_entry y;
        t_entry z;
    } t_quat;

    function automatic t_entry round_entry(input logic signed [QSUM_W-1:0] v);
        logic signed [QSUM_W-1:0] s;
        logic signed [QRND_W-1:0] t;
        t_entry                   e;
        s = v + QSUM_HALF;
        t = s[QSUM_W-1:FRAC_SHIFT];
        if (t > ENTRY_MAX) begin
            e = ENTRY_MAX[QUAT_WIDTH-1:0];
        end else if (t < ENTRY_MIN) begin
            e = ENTRY_MIN[QUAT_WIDTH-1:0];
        end else begin
            e = t[QUAT_WIDTH-1:0];
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/quaternion_rigid_point_transform_unit.sv -----
// Top level of the quaternion rigid point transform: config registers and pipeline.
//
// Rotates each Q16.16 point by the configured unit quaternion (Q1.14) and adds
// the Q16.16 translation, saturating each coordinate and flagging any clamp.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
// high; 0..3 are quat w,x,y,z, 4..6 are shift x,y,z. Unknown indexes are
// ignored. Write only while no point is in flight.
// Input: a point word is taken at each clock edge with i_start high; o_busy
// is always low, so one point can enter every cycle.
// Output: each result word is on o_out_* and o_saturated for one cycle with
// o_done high, once its point has passed all five register stages: quaternion
// products, matrix entries, matrix-by-point products, row sums, translation and
// saturation. Throughput is one word per cycle.
// The receiver cannot stall; results are never held back.
// Reset clears the pipeline valid bits and loads the identity rotation with
// zero translation.
`default_nettype none
module quaternion_rigid_point_transform_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [qrpt_pkg::INDEX_W-1:0]      i_cfg_index,
    input  wire logic [qrpt_pkg::COORD_WIDTH-1:0]  i_cfg_data,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic signed [qrpt_pkg::COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [qrpt_pkg::COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [qrpt_pkg::COORD_WIDTH-1:0] i_point_z,
    output logic                                   o_done,
    output logic signed [qrpt_pkg::COORD_WIDTH-1:0] o_out_x,
    output logic signed [qrpt_pkg::COORD_WIDTH-1:0] o_out_y,
    output logic signed [qrpt_pkg::COORD_WIDTH-1:0] o_out_z,
    output logic                                   o_saturated
);
    import qrpt_pkg::*;

    t_quat r_quat;
    t_vec  r_shift;
    t_vec  in_point;
    t_vec  mat_point;
    t_mat  mat;
    t_rvec rot;
    t_vec  out_vec;
    logic  in_valid;
    logic  mat_valid;
    logic  rot_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w   <= QUAT_ONE;
            r_quat.x   <= '0;
            r_quat.y   <= '0;
            r_quat.z   <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_QUAT_W:  r_quat.w   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_QUAT_X:  r_quat.x   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_QUAT_Y:  r_quat.y   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_QUAT_Z:  r_quat.z   <= i_cfg_data[QUAT_WIDTH-1:0];
                REG_SHIFT_X: r_shift[0] <= i_cfg_data;
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy      = 1'b0;
    assign in_valid    = i_start && !o_busy;
    assign in_point[0] = i_point_x;
    assign in_point[1] = i_point_y;
    assign in_point[2] = i_point_z;

    qrpt_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_point (in_point),
        .i_quat  (r_quat),
        .o_valid (mat_valid),
        .o_point (mat_point),
        .o_mat   (mat)
    );

    qrpt_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mat_valid),
        .i_point (mat_point),
        .i_mat   (mat),
        .o_valid (rot_valid),
        .o_rot   (rot)
    );

    qrpt_translate u_translate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (rot_valid),
        .i_rot       (rot),
        .i_shift     (r_shift),
        .o_valid     (o_done),
        .o_out       (out_vec),
        .o_saturated (o_saturated)
    );

    assign o_out_x = out_vec[0];
    assign o_out_y = out_vec[1];
    assign o_out_z = out_vec[2];

endmodule
`default_nettype wire

// ----- rtl/qrpt_matrix.sv -----
// Two stages: quaternion products, then rounded and clamped rotation matrix entries.
`default_nettype none
module qrpt_matrix (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire qrpt_pkg::t_vec i_point,
    input  wire qrpt_pkg::t_quat i_quat,
    output logic                o_valid,
    output qrpt_pkg::t_vec      o_point,
    output qrpt_pkg::t_mat      o_mat
);
    import qrpt_pkg::*;

    logic signed [QPROD_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [QPROD_W-1:0] n_xx, n_yy, n_zz, n_xy, n_xz, n_yz, n_wx, n_wy, n_wz;
    logic                      r_v1, r_v2;
    t_vec                      r_p1, r_p2;
    t_mat                      r_mat, n_mat;

    function automatic logic signed [QSUM_W-1:0] dbl(input logic signed [QPROD_W-1:0] p);
        logic signed [QSUM_W-1:0] e;
        e = {{2{p[QPROD_W-1]}}, p};
        return e <<< 1;
    endfunction

    always_comb begin
        n_xx = QPROD_W'(i_quat.x) * QPROD_W'(i_quat.x);
        n_yy = QPROD_W'(i_quat.y) * QPROD_W'(i_quat.y);
        n_zz = QPROD_W'(i_quat.z) * QPROD_W'(i_quat.z);
        n_xy = QPROD_W'(i_quat.x) * QPROD_W'(i_quat.y);
        n_xz = QPROD_W'(i_quat.x) * QPROD_W'(i_quat.z);
        n_yz = QPROD_W'(i_quat.y) * QPROD_W'(i_quat.z);
        n_wx = QPROD_W'(i_quat.w) * QPROD_W'(i_quat.x);
        n_wy = QPROD_W'(i_quat.w) * QPROD_W'(i_quat.y);
        n_wz = QPROD_W'(i_quat.w) * QPROD_W'(i_quat.z);
    end

    always_comb begin
        n_mat[0] = round_entry(Q28_ONE - dbl(r_yy) - dbl(r_zz));
        n_mat[1] = round_entry(dbl(r_xy) - dbl(r_wz));
        n_mat[2] = round_entry(dbl(r_xz) + dbl(r_wy));
        n_mat[3] = round_entry(dbl(r_xy) + dbl(r_wz));
        n_mat[4] = round_entry(Q28_ONE - dbl(r_xx) - dbl(r_zz));
        n_mat[5] = round_entry(dbl(r_yz) - dbl(r_wx));
        n_mat[6] = round_entry(dbl(r_xz) - dbl(r_wy));
        n_mat[7] = round_entry(dbl(r_yz) + dbl(r_wx));
        n_mat[8] = round_entry(Q28_ONE - dbl(r_xx) - dbl(r_yy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx  <= n_xx;
        r_yy  <= n_yy;
        r_zz  <= n_zz;
        r_xy  <= n_xy;
        r_xz  <= n_xz;
        r_yz  <= n_yz;
        r_wx  <= n_wx;
        r_wy  <= n_wy;
        r_wz  <= n_wz;
        r_p1  <= i_point;
        r_p2  <= r_p1;
        r_mat <= n_mat;
    end

    assign o_valid = r_v2;
    assign o_point = r_p2;
    assign o_mat   = r_mat;

endmodule
`default_nettype wire

// ----- rtl/qrpt_rotate.sv -----
// Two stages: matrix by point products, then row sums rounded back to Q16.16.
`default_nettype none
module qrpt_rotate (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire qrpt_pkg::t_vec i_point,
    input  wire qrpt_pkg::t_mat i_mat,
    output logic                o_valid,
    output qrpt_pkg::t_rvec     o_rot
);
    import qrpt_pkg::*;

    logic signed [PROD_W-1:0] r_prod [9];
    logic signed [PROD_W-1:0] n_prod [9];
    logic signed [ACC_W-1:0]  acc    [3];
    t_rvec                    r_rot, n_rot;
    logic                     r_v1, r_v2;

    function automatic logic signed [ACC_W-1:0] ext(input logic signed [PROD_W-1:0] p);
        return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[3*r+c] = PROD_W'(i_mat[3*r+c]) * PROD_W'(i_point[c]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = ext(r_prod[3*r]) + ext(r_prod[3*r+1]) + ext(r_prod[3*r+2])
                   + ACC_HALF;
            n_rot[r] = acc[r][ACC_W-1:FRAC_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_rot  <= n_rot;
    end

    assign o_valid = r_v2;
    assign o_rot   = r_rot;

endmodule
`default_nettype wire

// ----- rtl/qrpt_translate.sv -----
// Output stage: add the translation, saturate each coordinate, flag clamping.
`default_nettype none
module qrpt_translate (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire qrpt_pkg::t_rvec i_rot,
    input  wire qrpt_pkg::t_vec  i_shift,
    output logic                 o_valid,
    output qrpt_pkg::t_vec       o_out,
    output logic                 o_saturated
);
    import qrpt_pkg::*;

    logic signed [SUM_W-1:0] sum [3];
    t_vec                    r_out, n_out;
    logic                    r_sat, n_sat;
    logic                    r_valid;

    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            sum[r] = {i_rot[r][RND_W-1], i_rot[r]}
                   + {{(SUM_W-COORD_WIDTH){i_shift[r][COORD_WIDTH-1]}}, i_shift[r]};
            if (sum[r] > SUM_HI) begin
                n_out[r] = SUM_HI[COORD_WIDTH-1:0];
                n_sat    = 1'b1;
            end else if (sum[r] < SUM_LO) begin
                n_out[r] = SUM_LO[COORD_WIDTH-1:0];
                n_sat    = 1'b1;
            end else begin
                n_out[r] = sum[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sat <= n_sat;
    end

    assign o_valid     = r_valid;
    assign o_out       = r_out;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

// ----- dv/tb_quaternion_rigid_point_transform_unit.sv -----
// Self-checking testbench for the quaternion rigid point transform unit.
`timescale 1ns / 100ps

module tb_quaternion_rigid_point_transform_unit;
    import qrpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_POINTS   = 200;
    localparam int NUM_PHASES     = 8;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        t_vec pos;
        logic sat;
    } transformed_t;

    class transform_tracker;
        t_entry       quat_w, quat_x, quat_y, quat_z;
        t_coord       shift_x, shift_y, shift_z;
        transformed_t expected_q[$];
        int           errors;
        int           checked;
        int           clamped;

        function new();
            quat_w  = QUAT_ONE;
            quat_x  = '0;
            quat_y  = '0;
            quat_z  = '0;
            shift_x = '0;
            shift_y = '0;
            shift_z = '0;
            errors  = 0;
            checked = 0;
            clamped = 0;
        endfunction

        function void set_register(logic [INDEX_W-1:0] idx, logic [COORD_WIDTH-1:0] data);
            case (idx)
                REG_QUAT_W:  quat_w  = data[QUAT_WIDTH-1:0];
                REG_QUAT_X:  quat_x  = data[QUAT_WIDTH-1:0];
                REG_QUAT_Y:  quat_y  = data[QUAT_WIDTH-1:0];
                REG_QUAT_Z:  quat_z  = data[QUAT_WIDTH-1:0];
                REG_SHIFT_X: shift_x = data;
                REG_SHIFT_Y: shift_y = data;
                REG_SHIFT_Z: shift_z = data;
                default: ;
            endcase
        endfunction

        function longint round_q14(longint v);
            return (v + 64'sd8192) >>> FRAC_SHIFT;
        endfunction

        function longint entry_of(longint q28);
            longint e;
            e = round_q14(q28);
            if (e > 32767) e = 32767;
            if (e < -32768) e = -32768;
            return e;
        endfunction

        function transformed_t transform(t_vec p);
            longint       w, x, y, z, one, hi, lo, acc, v;
            longint       m[9];
            longint       t[3];
            transformed_t res;
            w   = longint'(quat_w);
            x   = longint'(quat_x);
            y   = longint'(quat_y);
            z   = longint'(quat_z);
            one = 64'sd1 <<< 28;
            hi  = (64'sd1 <<< (COORD_WIDTH-1)) - 1;
            lo  = -hi - 1;
            m[0] = entry_of(one - 2*y*y - 2*z*z);
            m[1] = entry_of(2*x*y - 2*w*z);
            m[2] = entry_of(2*x*z + 2*w*y);
            m[3] = entry_of(2*x*y + 2*w*z);
            m[4] = entry_of(one - 2*x*x - 2*z*z);
            m[5] = entry_of(2*y*z - 2*w*x);
            m[6] = entry_of(2*x*z - 2*w*y);
            m[7] = entry_of(2*y*z + 2*w*x);
            m[8] = entry_of(one - 2*x*x - 2*y*y);
            t[0] = longint'(shift_x);
            t[1] = longint'(shift_y);
            t[2] = longint'(shift_z);
            res.sat = 1'b0;
            for (int r = 0; r < 3; r++) begin
                acc = 0;
                for (int c = 0; c < 3; c++) begin
                    acc += m[r*3+c] * longint'($signed(p[c]));
                end
                v = round_q14(acc) + t[r];
                if (v > hi) begin
                    v = hi;
                    res.sat = 1'b1;
                end
                if (v < lo) begin
                    v = lo;
                    res.sat = 1'b1;
                end
                res.pos[r] = v[COORD_WIDTH-1:0];
            end
            return res;
        endfunction

        function void note_point(t_vec p);
            expected_q.push_back(transform(p));
        endfunction

        function void check_result(t_vec got, logic sat);
            transformed_t e;
            string        axis = "xyz";
            if (expected_q.size() == 0) begin
                $error("result word with no point pending");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.sat) clamped++;
            for (int c = 0; c < 3; c++) begin
                if (got[c] !== e.pos[c]) begin
                    $error("out_%s mismatch: expected %0d, got %0d", axis.substr(c, c),
                           $signed(e.pos[c]), $signed(got[c]));
                    errors++;
                end
            end
            if (sat !== e.sat) begin
                $error("saturated mismatch: expected %0d, got %0d", e.sat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [INDEX_W-1:0]     i_cfg_index;
    logic [COORD_WIDTH-1:0] i_cfg_data;
    logic                   i_start;
    logic                   o_busy;
    t_coord                 i_point_x, i_point_y, i_point_z;
    logic                   o_done;
    t_coord                 o_out_x, o_out_y, o_out_z;
    logic                   o_saturated;

    transform_tracker tracker = new();
    int               stall_cycles = 0;
    int               idle_pct = 0;
    int               sent = 0;
    int               settings = 0;

    quaternion_rigid_point_transform_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .o_done      (o_done),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            tracker.check_result({o_out_z, o_out_y, o_out_x}, o_saturated);
        end
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_vec xyz(t_coord x, t_coord y, t_coord z);
        return {z, y, x};
    endfunction

    function automatic t_quat quat(int w, int x, int y, int z);
        t_quat q;
        q.w = w[QUAT_WIDTH-1:0];
        q.x = x[QUAT_WIDTH-1:0];
        q.y = y[QUAT_WIDTH-1:0];
        q.z = z[QUAT_WIDTH-1:0];
        return q;
    endfunction

    function automatic t_coord rand_coord();
        logic signed [19:0] s20;
        logic signed [23:0] s24;
        s20 = 20'($urandom);
        s24 = 24'($urandom);
        case ($urandom_range(3))
            0: return $urandom;
            1: return t_coord'(s20);
            2: begin
                case ($urandom_range(4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return t_coord'(s24);
        endcase
    endfunction

    function automatic t_coord pick_shift();
        logic signed [23:0] s24;
        s24 = 24'($urandom);
        case ($urandom_range(3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return t_coord'(s24);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_quat_extreme();
        case ($urandom_range(2))
            0: return -16384;
            1: return 0;
            default: return 16384;
        endcase
    endfunction

    task automatic drain();
        i_start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [COORD_WIDTH-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.set_register(idx, data);
    endtask

    task automatic apply_config(t_quat q, t_coord sx, t_coord sy, t_coord sz);
        logic [QUAT_WIDTH-1:0] junk;
        junk = 16'($urandom);
        drain();
        write_reg(REG_QUAT_W, {junk, q.w});
        write_reg(REG_QUAT_X, {~junk, q.x});
        write_reg(REG_QUAT_Y, {junk, q.y});
        write_reg(REG_QUAT_Z, {~junk, q.z});
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_SHIFT_Z, sz);
        write_reg(REG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_point(t_vec p);
        while ($urandom_range(99) < idle_pct) begin
            i_start   <= 1'b0;
            i_point_x <= $urandom;
            i_point_y <= $urandom;
            i_point_z <= $urandom;
            @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_point_x <= p[0];
        i_point_y <= p[1];
        i_point_z <= p[2];
        do @(posedge i_clk); while (o_busy);
        tracker.note_point(p);
        sent++;
    endtask

    initial begin
        real    a, b, c, d, n;
        t_quat  q;
        t_coord sx, sy, sz;
        logic signed [15:0] s16;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_QUAT_W;
        i_cfg_data  <= '0;
        i_start     <= 1'b0;
        i_point_x   <= '0;
        i_point_y   <= '0;
        i_point_z   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity rotation and zero translation out of reset
        send_point(xyz(0, 0, 0));
        send_point(xyz(COORD_MAX, COORD_MIN, -1));
        send_point(xyz(COORD_MIN, COORD_MAX, 1));
        send_point(xyz(-1, 1, 32'sh0001_0000));

        // half turn about z with extreme translation: clamp high and low
        apply_config(quat(0, 0, 0, 16384), COORD_MAX, COORD_MIN, 0);
        send_point(xyz(COORD_MIN, COORD_MIN, COORD_MIN));
        send_point(xyz(COORD_MAX, COORD_MAX, COORD_MAX));
        send_point(xyz(1, -1, 0));

        // quaternion far from unit length: matrix entries clamp
        apply_config(quat(-16384, -16384, -16384, -16384), 0, 0, 0);
        send_point(xyz(COORD_MAX, COORD_MIN, 1));
        send_point(xyz(12345, -678, -9));
        send_point(xyz(COORD_MIN, COORD_MIN, COORD_MIN));
        apply_config(quat(16384, 16384, 16384, 16384), COORD_MIN, COORD_MAX, COORD_MIN);
        send_point(xyz(COORD_MIN, COORD_MIN, COORD_MAX));
        send_point(xyz(COORD_MAX, 0, -1));
        send_point(xyz(-5, 7, 3));

        // sixty degrees about z: entries of exactly one half, ties in rounding
        apply_config(quat(14189, 0, 0, 8192), 0, 0, 1);
        send_point(xyz(1, 0, 0));
        send_point(xyz(-1, 0, 0));
        send_point(xyz(3, 0, 0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 73;
                default: idle_pct = 13;
            endcase
            sx = pick_shift();
            sy = pick_shift();
            sz = pick_shift();
            case (ph % 4)
                0, 3: begin
                    a = real'($urandom_range(20000)) - 10000.0;
                    b = real'($urandom_range(20000)) - 10000.0;
                    c = real'($urandom_range(20000)) - 10000.0;
                    d = real'($urandom_range(20000)) - 10000.0;
                    n = $sqrt(a*a + b*b + c*c + d*d);
                    if (n < 1.0) begin
                        q = quat(16384, 0, 0, 0);
                    end else begin
                        q = quat($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                                 $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
                    end
                    if (ph % 4 == 3) begin
                        s16 = 16'($urandom);
                        sx = t_coord'(s16);
                        s16 = 16'($urandom);
                        sy = t_coord'(s16);
                        s16 = 16'($urandom);
                        sz = t_coord'(s16);
                    end
                end
                1: q = quat($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                            $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
                default: q = quat(pick_quat_extreme(), pick_quat_extreme(),
                                  pick_quat_extreme(), pick_quat_extreme());
            endcase
            apply_config(q, sx, sy, sz);
            for (int i = 0; i < PHASE_POINTS; i++) begin
                send_point(xyz(rand_coord(), rand_coord(), rand_coord()));
            end
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d points under %0d register settings, sender idle 0/13/73 percent.",
                 sent, settings);
        $display("Checked %0d result words, %0d clamped, %0d mismatches.",
                 tracker.checked, tracker.clamped, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/qrpt_pkg.sv
rtl/qrpt_matrix.sv
rtl/qrpt_rotate.sv
rtl/qrpt_translate.sv
rtl/quaternion_rigid_point_transform_unit.sv
dv/tb_quaternion_rigid_point_transform_unit.sv
